// ----- rtl/mmm_pkg.sv -----
// Shared constants, codes and types for the multirotor motor mixer.
// No dependencies; imported by the mixer and its port checker.
`default_nettype none

package mmm_pkg;

    localparam int MAX_MOTORS  = 8;
    localparam int MOTOR_LIMIT = (MAX_MOTORS < 8) ? MAX_MOTORS : 8;
    localparam int ROW_W       = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int CHANNELS    = 4;

    localparam int DATA_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 12;
    localparam int SHIFT_W  = ACC_W - FRAC_W;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 24;
    localparam int CFG_AW    = 2;

    localparam logic [3:0]        MOTOR_COUNT_RST = 4'd4;
    localparam logic [DATA_W-1:0] MIN_VEL_RST     = 16'sd0;
    localparam logic [DATA_W-1:0] MAX_VEL_RST     = 16'sd25600;

    typedef enum logic {
        OP_MIX   = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MOTOR_COUNT = 2'd0,
        CFG_MIN_VEL     = 2'd1,
        CFG_MAX_VEL     = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/multirotor_motor_mixer.sv -----
// Multirotor motor mixer: coefficient table, one shared multiply-accumulate unit,
// clamp and an output register. Depends on mmm_pkg.
//
// channel   direction  handshake               payload
// s_axis    in         tvalid/tready           tuser: op; tdata: power, roll, pitch, yaw,
//                                              table_motor, table_channel, coefficient
// m_axis    out        tvalid/tready/tlast     tuser: motor_used; tdata: motor_number,
//                                              velocity; tlast: last
// cfg       in         i_cfg_we                i_cfg_addr, i_cfg_wdata
//
// A mix works through the motors one at a time, each in four passes
// through the shared multiplier, one final add and one clamp into the output register.
// A stalled output holds the mixer in its clamp step until the register frees up.
// Reset clears the coefficient table and loads the register defaults.
`default_nettype none

module multirotor_motor_mixer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] power, [31:16] roll, [47:32] pitch, [63:48] yaw,
    // [66:64] table_motor, [68:67] table_channel, [84:69] coefficient
    input  wire logic [mmm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [2:0] motor_number, [18:3] velocity
    output logic [mmm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [0] motor_used
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_we,
    input  wire logic [mmm_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [mmm_pkg::DATA_W-1:0]     i_cfg_wdata
);
    import mmm_pkg::*;

    t_state                     r_state;
    logic [3:0]                 r_motor_count;
    logic signed [DATA_W-1:0]   r_min;
    logic signed [DATA_W-1:0]   r_max;
    logic signed [DATA_W-1:0]   r_tbl [MAX_MOTORS][CHANNELS];
    logic signed [DATA_W-1:0]   r_ch [CHANNELS];
    logic [2:0]                 r_motor;
    logic [2:0]                 r_last_motor;
    logic [1:0]                 r_chan;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_used;
    logic                       r_out_valid;
    logic [2:0]                 r_out_num;
    logic signed [DATA_W-1:0]   r_out_vel;
    logic                       r_out_used;
    logic                       r_out_last;

    logic                       s_accept;
    logic                       out_free;
    logic                       out_load;
    logic [3:0]                 count_sat;
    logic signed [DATA_W-1:0]   coef;
    logic signed [SHIFT_W-1:0]  shifted;
    logic signed [DATA_W-1:0]   clamped;
    logic [2:0]                 in_motor;
    logic [1:0]                 in_chan;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == ST_EMIT) && out_free;
    assign in_motor      = s_axis_tdata[66:64];
    assign in_chan       = s_axis_tdata[68:67];

    assign count_sat = (r_motor_count > 4'(MOTOR_LIMIT)) ? 4'(MOTOR_LIMIT) : r_motor_count;
    assign coef      = r_tbl[ROW_W'(r_motor)][r_chan];
    assign shifted   = r_acc[ACC_W-1:FRAC_W];

    always_comb begin
        if (!r_used) begin
            clamped = '0;
        end else if (shifted < SHIFT_W'(r_min)) begin
            clamped = r_min;
        end else if (shifted > SHIFT_W'(r_max)) begin
            clamped = r_max;
        end else begin
            clamped = shifted[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= MOTOR_COUNT_RST;
            r_min         <= MIN_VEL_RST;
            r_max         <= MAX_VEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MOTOR_COUNT: r_motor_count <= i_cfg_wdata[3:0];
                CFG_MIN_VEL:     r_min         <= i_cfg_wdata;
                CFG_MAX_VEL:     r_max         <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MAX_MOTORS; m++) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_tbl[m][c] <= '0;
                end
            end
        end else if (s_accept && t_op'(s_axis_tuser) == OP_WRITE
                     && 32'(in_motor) < MAX_MOTORS) begin
            r_tbl[ROW_W'(in_motor)][in_chan] <= s_axis_tdata[84:69];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_accept && t_op'(s_axis_tuser) == OP_MIX && count_sat != '0) begin
                        r_ch[0]      <= s_axis_tdata[15:0];
                        r_ch[1]      <= s_axis_tdata[31:16];
                        r_ch[2]      <= s_axis_tdata[47:32];
                        r_ch[3]      <= s_axis_tdata[63:48];
                        r_last_motor <= 3'(count_sat - 4'd1);
                        r_motor      <= '0;
                        r_chan       <= '0;
                        r_state      <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_prod <= r_ch[r_chan] * coef;
                    r_acc  <= (r_chan == '0) ? '0 : r_acc + ACC_W'(r_prod);
                    r_used <= (r_chan == '0) ? (coef != '0) : (r_used || coef != '0);
                    r_chan <= r_chan + 2'd1;
                    if (r_chan == 2'(CHANNELS - 1)) begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_num   <= r_motor;
                        r_out_vel   <= clamped;
                        r_out_used  <= r_used;
                        r_out_last  <= (r_motor == r_last_motor);
                        if (r_motor == r_last_motor) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_motor <= r_motor + 3'd1;
                            r_chan  <= '0;
                            r_state <= ST_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_vel, r_out_num};
    assign m_axis_tuser  = r_out_used;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/mmm_port_checker.sv -----
// Port-level checks for the multirotor motor mixer, bound to its top level.
// Depends on mmm_pkg and multirotor_motor_mixer.
`default_nettype none

module mmm_port_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [mmm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                           m_axis_tuser,
    input  wire logic                           m_axis_tlast
);
    import mmm_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken before the last motor beat");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[DATA_W+2:3] == '0)
        else $error("unused motor with nonzero velocity");

endmodule

bind multirotor_motor_mixer mmm_port_checker u_mmm_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- dv/multirotor_motor_mixer_tb.sv -----
// Self-checking testbench for multirotor_motor_mixer: mirrors the coefficient table and clamp
// registers, predicts each motor beat and checks the m_axis stream under random back-pressure.
// Depends on rtl/mmm_pkg.sv and rtl/multirotor_motor_mixer.sv.
`default_nettype none

module multirotor_motor_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmm_pkg::*;

    typedef struct packed {
        logic [2:0]  motor;
        logic [15:0] vel;
        logic        used;
        logic        last;
    } t_motor_beat;

    class mix_scoreboard;
        logic signed [DATA_W-1:0] coef_tbl [MAX_MOTORS][CHANNELS];
        logic [3:0]               motor_count;
        logic signed [DATA_W-1:0] min_vel;
        logic signed [DATA_W-1:0] max_vel;
        t_motor_beat              expected_velocities [$];
        int                       n_err;

        function new();
            foreach (coef_tbl[m, c]) coef_tbl[m][c] = '0;
            motor_count = MOTOR_COUNT_RST;
            min_vel     = MIN_VEL_RST;
            max_vel     = MAX_VEL_RST;
            n_err       = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [DATA_W-1:0] val);
            case (idx)
                CFG_MOTOR_COUNT: motor_count = val[3:0];
                CFG_MIN_VEL:     min_vel = val;
                CFG_MAX_VEL:     max_vel = val;
                default: ;
            endcase
        endfunction

        function void predict_velocities(logic [63:0] chans);
            int          n;
            longint      acc;
            longint      v;
            logic        used;
            t_motor_beat b;
            n = (motor_count > MOTOR_LIMIT) ? MOTOR_LIMIT : int'(motor_count);
            for (int m = 0; m < n; m++) begin
                acc  = 0;
                used = 1'b0;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (coef_tbl[m][c] != 0) used = 1'b1;
                    acc += longint'($signed(chans[16*c +: 16])) * longint'(coef_tbl[m][c]);
                end
                v = 0;
                if (used) begin
                    v = acc >>> FRAC_W;
                    if (v < min_vel) v = min_vel;
                    else if (v > max_vel) v = max_vel;
                end
                b.motor = m[2:0];
                b.vel   = v[15:0];
                b.used  = used;
                b.last  = (m + 1 == n);
                expected_velocities.push_back(b);
            end
        endfunction

        function void note_beat(t_op op, logic [S_TDATA_W-1:0] data);
            int row;
            int col;
            if (op == OP_WRITE) begin
                row = int'(data[66:64]);
                col = int'(data[68:67]);
                if (row < MAX_MOTORS) coef_tbl[row][col] = data[84:69];
            end else begin
                predict_velocities(data[63:0]);
            end
        endfunction

        function void check_beat(t_motor_beat got);
            t_motor_beat want;
            if (expected_velocities.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("%0t: unexpected beat motor=%0d vel=%h used=%b last=%b",
                             $realtime, got.motor, got.vel, got.used, got.last);
                return;
            end
            want = expected_velocities.pop_front();
            if (got.motor !== want.motor || got.vel !== want.vel ||
                got.used !== want.used || got.last !== want.last) begin
                n_err++;
                if (n_err <= 10)
                    $display("%0t: mismatch exp motor=%0d vel=%h used=%b last=%b, got motor=%0d vel=%h used=%b last=%b",
                             $realtime, want.motor, want.vel, want.used, want.last,
                             got.motor, got.vel, got.used, got.last);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [15:0] power, [31:16] roll, [47:32] pitch, [63:48] yaw,
    // [66:64] table_motor, [68:67] table_channel, [84:69] coefficient
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    // [0] op
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [2:0] motor_number, [18:3] velocity
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    // [0] motor_used
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_we;
    logic [CFG_AW-1:0]      i_cfg_addr;
    logic [DATA_W-1:0]      i_cfg_wdata;

    int idle_pct  = 0;
    int stall_pct = 0;

    mix_scoreboard sb = new();

    multirotor_motor_mixer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat({m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tuser, m_axis_tlast});
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [15:0] pw, logic [15:0] rl,
                                                       logic [15:0] pt, logic [15:0] yw,
                                                       logic [2:0] row, logic [1:0] col,
                                                       logic [15:0] coef);
        return {3'b000, coef, col, row, yw, pt, rl, pw};
    endfunction

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(4096)) - 16'd2048;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'($urandom);
            2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(8192)) - 16'd4096;
        endcase
    endfunction

    task automatic send_beat(t_op op, logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(op, data);
    endtask

    task automatic mix(logic [15:0] pw, logic [15:0] rl, logic [15:0] pt, logic [15:0] yw);
        send_beat(OP_MIX, pack_item(pw, rl, pt, yw, 3'($urandom), 2'($urandom),
                                    16'($urandom)));
    endtask

    task automatic write_coef(logic [2:0] row, logic [1:0] col, logic [15:0] coef);
        send_beat(OP_WRITE, pack_item(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), row, col, coef));
    endtask

    // hold off until every beat is out, then let a full eight-motor mix pass
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_velocities.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] count, logic [15:0] vmin, logic [15:0] vmax);
        t_cfg_reg    idx  [3];
        logic [15:0] vals [3];
        idx  = '{CFG_MOTOR_COUNT, CFG_MIN_VEL, CFG_MAX_VEL};
        vals = '{count, vmin, vmax};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) begin
            if ($urandom_range(99) < 30)
                write_coef(3'($urandom_range(7)), 2'($urandom_range(3)), rand_coef());
            else
                mix(rand_chan(), rand_chan(), rand_chan(), rand_chan());
        end
        settle();
    endtask

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= OP_MIX;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_MOTOR_COUNT;
        i_cfg_wdata   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared table, default registers
        mix(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        write_coef(3'd0, 2'd0, 16'h1000);
        write_coef(3'd1, 2'd1, 16'hF000);
        write_coef(3'd2, 2'd3, 16'h7FFF);
        write_coef(3'd3, 2'd2, 16'h8000);
        write_coef(3'd7, 2'd3, 16'hFFFF);
        mix(16'h0100, 16'h0100, 16'h0100, 16'h0100);
        mix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        mix(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        mix(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        mix(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        write_coef(3'd0, 2'd0, 16'h0000);
        write_coef(3'd0, 2'd1, 16'h0001);
        mix(16'h0FFF, 16'hF001, 16'h0000, 16'h0000);
        mix(16'h6400, 16'hFF00, 16'h0080, 16'hFFFF);
        settle();

        configure(16'd8, 16'h8000, 16'h7FFF);
        run_phase(14, 0, 0);
        configure(16'd15, 16'hFF00, 16'h0A00);
        run_phase(20, 81, 0);
        configure(16'd1, 16'd1000, 16'hFC18);
        run_phase(15, 0, 81);
        configure(16'd0, 16'h0000, 16'h6400);
        run_phase(8, 23, 23);
        configure(16'd6, 16'h7FFF, 16'h8000);
        run_phase(12, 23, 23);
        run_phase(12, 23, 23);
        configure(16'd3, 16'd500, 16'd500);
        run_phase(15, 0, 0);

        if (sb.n_err == 0 && sb.expected_velocities.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
